>>> design/lsmi_pkg.sv
// Package for the limit switch motor interlock.
// Holds sizes, command and result codes, register indexes and reset values.
// No dependencies.
package lsmi_pkg;

	localparam int NUM_SWITCHES = 16;
	localparam int NUM_MOTORS   = 5;

	localparam int SW_IDX_W = 4;   // width of limit_index / report_index
	localparam int MOTOR_W  = 3;   // width of motor fields
	localparam int MOTOR_SLOTS = 8;
	localparam int CFG_W    = 32;

	localparam logic [SW_IDX_W-1:0] LAST_SW = SW_IDX_W'(NUM_SWITCHES - 1);

	// commands
	localparam logic [1:0] CMD_EVENT = 2'd0;
	localparam logic [1:0] CMD_SWEEP = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_REPORT  = 2'd0;
	localparam logic [1:0] KIND_STOP    = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ACTIVE_LOW_MASK = 2'd0;
	localparam logic [1:0] REG_LIMIT_MAP_LOW   = 2'd1;
	localparam logic [1:0] REG_LIMIT_MAP_HIGH  = 2'd2;

	localparam logic [15:0] RST_ACTIVE_LOW_MASK = 16'h9FD5;
	localparam logic [31:0] RST_LIMIT_MAP_LOW   = 32'hE6452301;
	localparam logic [31:0] RST_LIMIT_MAP_HIGH  = 32'hEEE9E87E;

	typedef struct packed {
		logic [1:0]          kind;
		logic [SW_IDX_W-1:0] idx;
		logic                st;
		logic [MOTOR_W-1:0]  motor;
		logic                blk;
	} result_t;

endpackage

>>> design/limit_switch_motor_interlock.sv
// Top level of the limit switch motor interlock.
// Depends on lsmi_pkg for sizes, codes and the result word type.
//
// Usage: a command word comes in on cmd_valid/cmd_stall, result words leave on
// res_valid/res_stall, each field on a port of its own. A word is taken at a
// rising edge with valid high and stall low. cfg_we/cfg_index/cfg_data write the mask
// and the two limit maps, only while the block is idle: a rule for the user, not enforced.
// One sequencer walks the switches one per cycle, pausing while a result is held up,
// through a single shared nibble-select and compare unit:
//   switch event: one sync step and one stop step for limit_index, then the flush step,
//   sweep: NUM_SWITCHES sync steps, then NUM_SWITCHES stop steps, then the flush step,
//   start check: NUM_SWITCHES check steps, then the flush step.
// A result sits in a pending register and reaches the output at the step that
// finds the next result, or at the flush step that ends the item (with last set).
// cmd_stall is high while an item runs.
// When the receiver holds res_stall, the output register keeps its word and the
// sequencer pauses on the next step that has a result to hand over.
// Reset (arst_n low) clears switch states, restores register reset values and
// empties the output; the block is ready as soon as reset is released.
module limit_switch_motor_interlock (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [lsmi_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [1:0]                   command,
	input  logic [15:0]                  raw_pins,
	input  logic [lsmi_pkg::SW_IDX_W-1:0] limit_index,
	input  logic [lsmi_pkg::NUM_MOTORS-1:0] motors_running,
	input  logic [lsmi_pkg::NUM_MOTORS-1:0] motor_directions,
	input  logic [lsmi_pkg::MOTOR_W-1:0] request_motor,
	input  logic                         request_direction,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [1:0]                   kind,
	output logic [lsmi_pkg::SW_IDX_W-1:0] report_index,
	output logic                         report_state,
	output logic [lsmi_pkg::MOTOR_W-1:0] stop_motor,
	output logic                         blocked,
	output logic                         last
);
	import lsmi_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SYNC,
		S_STOP,
		S_CHECK,
		S_FLUSH
	} state_t;

	localparam logic [15:0] SW_MASK = 16'((17'(1) << NUM_SWITCHES) - 17'(1));

	state_t                 state_q;
	logic [15:0]            mask_q;
	logic [31:0]            map_lo_q;
	logic [31:0]            map_hi_q;
	logic [15:0]            sw_state_q;
	logic [15:0]            logical_q;
	logic [SW_IDX_W-1:0]    ptr_q;
	logic                   single_q;
	logic [NUM_MOTORS-1:0]  running_q;
	logic [NUM_MOTORS-1:0]  dirs_q;
	logic [MOTOR_W-1:0]     rmotor_q;
	logic                   rdir_q;
	logic                   blk_q;
	logic                   pend_v_q;
	result_t                pend_q;
	logic                   res_valid_q;
	result_t                res_q;
	logic                   last_q;

	// shared step unit
	logic [63:0]            map_all;
	logic [3:0]             nib;
	logic [MOTOR_W-1:0]     nib_motor;
	logic                   nib_in_range;
	logic [MOTOR_SLOTS-1:0] run_ext;
	logic [MOTOR_SLOTS-1:0] dir_ext;
	logic [MOTOR_SLOTS-1:0] motor_onehot;
	logic                   changed;
	logic                   stop_hit;
	logic                   blk_acc;
	logic                   at_end;
	logic                   emit_now;
	result_t                new_res;
	logic                   out_free;
	logic                   go;

	assign map_all      = {map_hi_q, map_lo_q};
	assign nib          = map_all[{ptr_q, 2'b00} +: 4];
	assign nib_motor    = nib[3:1];
	assign nib_in_range = {1'b0, nib_motor} < (MOTOR_W + 1)'(NUM_MOTORS);
	assign run_ext      = MOTOR_SLOTS'(running_q);
	assign dir_ext      = MOTOR_SLOTS'(dirs_q);
	assign motor_onehot = MOTOR_SLOTS'(1) << nib_motor;
	assign changed      = logical_q[ptr_q] ^ sw_state_q[ptr_q];
	assign stop_hit     = nib_in_range && sw_state_q[ptr_q] && run_ext[nib_motor]
	                      && (dir_ext[nib_motor] == nib[0]);
	assign blk_acc      = blk_q || ((nib_motor == rmotor_q) && (nib[0] == rdir_q)
	                      && sw_state_q[ptr_q]);
	assign at_end       = single_q || (ptr_q == LAST_SW);
	assign out_free     = !res_valid_q || !res_stall;

	always_comb begin
		emit_now = 1'b0;
		new_res  = '0;
		case (state_q)
			S_SYNC: begin
				emit_now     = changed;
				new_res.kind = KIND_REPORT;
				new_res.idx  = ptr_q;
				new_res.st   = logical_q[ptr_q];
			end
			S_STOP: begin
				emit_now      = stop_hit;
				new_res.kind  = KIND_STOP;
				new_res.motor = nib_motor;
			end
			S_CHECK: begin
				emit_now     = (ptr_q == LAST_SW);
				new_res.kind = KIND_VERDICT;
				new_res.blk  = blk_acc;
			end
			default: begin
				emit_now = 1'b0;
			end
		endcase
	end

	// a step that hands a result over waits while the older pending word has nowhere to go
	assign go = !(emit_now && pend_v_q && !out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mask_q      <= RST_ACTIVE_LOW_MASK;
			map_lo_q    <= RST_LIMIT_MAP_LOW;
			map_hi_q    <= RST_LIMIT_MAP_HIGH;
			sw_state_q  <= '0;
			logical_q   <= '0;
			ptr_q       <= '0;
			single_q    <= 1'b0;
			running_q   <= '0;
			dirs_q      <= '0;
			rmotor_q    <= '0;
			rdir_q      <= 1'b0;
			blk_q       <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE_LOW_MASK: mask_q   <= cfg_data[15:0];
					REG_LIMIT_MAP_LOW:   map_lo_q <= cfg_data;
					REG_LIMIT_MAP_HIGH:  map_hi_q <= cfg_data;
					default: ;
				endcase
			end

			if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			// move the pending word out once a newer one shows up
			if (go && emit_now) begin
				if (pend_v_q) begin
					res_valid_q <= 1'b1;
					res_q       <= pend_q;
					last_q      <= 1'b0;
				end
				pend_v_q <= 1'b1;
				pend_q   <= new_res;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						logical_q <= (raw_pins ^ mask_q) & SW_MASK;
						running_q <= motors_running;
						dirs_q    <= motor_directions;
						rmotor_q  <= request_motor;
						rdir_q    <= request_direction;
						blk_q     <= {1'b0, request_motor} >= (MOTOR_W + 1)'(NUM_MOTORS);
						case (command)
							CMD_EVENT: begin
								ptr_q    <= limit_index;
								single_q <= 1'b1;
								if ({1'b0, limit_index} < (SW_IDX_W + 1)'(NUM_SWITCHES)) begin
									state_q <= S_SYNC;
								end
							end
							CMD_SWEEP: begin
								ptr_q    <= '0;
								single_q <= 1'b0;
								state_q  <= S_SYNC;
							end
							CMD_START: begin
								ptr_q    <= '0;
								single_q <= 1'b0;
								state_q  <= S_CHECK;
							end
							default: ;
						endcase
					end
				end
				S_SYNC: begin
					if (go) begin
						if (changed) begin
							sw_state_q[ptr_q] <= logical_q[ptr_q];
						end
						if (at_end) begin
							state_q <= S_STOP;
							if (!single_q) begin
								ptr_q <= '0;
							end
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_STOP: begin
					if (go) begin
						if (stop_hit) begin
							running_q <= running_q & ~motor_onehot[NUM_MOTORS-1:0];
						end
						if (at_end) begin
							state_q <= S_FLUSH;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_CHECK: begin
					if (go) begin
						blk_q <= blk_acc;
						if (ptr_q == LAST_SW) begin
							state_q <= S_FLUSH;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						res_valid_q <= 1'b1;
						res_q       <= pend_q;
						last_q      <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall    = (state_q != S_IDLE);
	assign res_valid    = res_valid_q;
	assign kind         = res_q.kind;
	assign report_index = res_q.idx;
	assign report_state = res_q.st;
	assign stop_motor   = res_q.motor;
	assign blocked      = res_q.blk;
	assign last         = last_q;

endmodule
